[rtl/rpn_stack_calculator_assert.svh]
// assertion macros for the rpn stack calculator checker
// expects signals named clk and rst_n in the scope of use
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RPN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rpn_pkg.sv]
// shared types and constants for the rpn stack calculator
// no dependencies
package rpn_pkg;

    localparam int Q_W = 32;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        KIND_PUSH    = 3'd0,
        KIND_ADD     = 3'd1,
        KIND_SUB     = 3'd2,
        KIND_MUL     = 3'd3,
        KIND_DIV     = 3'd4,
        KIND_MOD     = 3'd5,
        KIND_SHOW    = 3'd6,
        KIND_UNKNOWN = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_R,
        ST_GET_R,
        ST_RD_L,
        ST_GET_L,
        ST_EXEC,
        ST_MUL_SAT,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic is_mod;
    } div_ctrl_t;

endpackage

[rtl/rpn_token_if.sv]
// token channel: one operation or operand per transfer
// depends on rpn_pkg
interface rpn_token_if;
    logic              valid;
    logic              ready;
    rpn_pkg::kind_t    kind;
    logic signed [31:0] number;

    modport source (output valid, output kind, output number, input ready);
    modport sink (input valid, input kind, input number, output ready);
endinterface

[rtl/rpn_result_if.sv]
// result channel: one transfer per token, printed value and error flags
// no dependencies
interface rpn_result_if;
    logic               valid;
    logic               ready;
    logic               shown_valid;
    logic signed [31:0] shown_value;
    logic               overflow_error;
    logic               underflow_error;
    logic               zero_divisor_error;
    logic               unknown_error;

    modport source (
        output valid, output shown_valid, output shown_value, output overflow_error,
        output underflow_error, output zero_divisor_error, output unknown_error,
        input ready
    );
    modport sink (
        input valid, input shown_valid, input shown_value, input overflow_error,
        input underflow_error, input zero_divisor_error, input unknown_error,
        output ready
    );
endinterface

[rtl/rpn_mem.sv]
// operand stack memory, one write port and one registered read port
// depends on rpn_pkg
module rpn_mem #(
    parameter int DEPTH = 128
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic signed [rpn_pkg::Q_W-1:0]   wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic signed [rpn_pkg::Q_W-1:0]   rd_data
);
    import rpn_pkg::*;

    logic signed [Q_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/rpn_div.sv]
// iterative restoring divider, one quotient bit per cycle
// truncating q16.16 divide with saturation, or floor modulo; depends on rpn_pkg
module rpn_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rpn_pkg::div_ctrl_t             ctrl,
    input  logic signed [rpn_pkg::Q_W-1:0] left,
    input  logic signed [rpn_pkg::Q_W-1:0] right,
    output logic                           done,
    output logic signed [rpn_pkg::Q_W-1:0] result
);
    import rpn_pkg::*;

    localparam int STEPS = 48;
    localparam int CW = $clog2(STEPS + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [47:0]   quo_reg, quo_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   dvs_reg, dvs_next;
    logic          mod_reg, mod_next;
    logic          sl_reg, sl_next;
    logic          sr_reg, sr_next;
    logic signed [Q_W-1:0] right_reg, right_next;

    logic [31:0] lmag;
    logic [31:0] rmag;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;
    logic signed [32:0] m_trunc;
    logic signed [32:0] m_floor;
    logic signed [Q_W-1:0] q_val;

    assign lmag   = left[Q_W-1] ? (~left + 32'd1) : left;
    assign rmag   = right[Q_W-1] ? (~right + 32'd1) : right;
    assign rem_sh = {rem_reg, quo_reg[47]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        mod_next   = mod_reg;
        sl_next    = sl_reg;
        sr_next    = sr_reg;
        right_next = right_reg;
        if (ctrl.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CW'(STEPS);
            quo_next   = ctrl.is_mod ? {16'd0, lmag} : {lmag, 16'd0};
            rem_next   = '0;
            dvs_next   = rmag;
            mod_next   = ctrl.is_mod;
            sl_next    = left[Q_W-1];
            sr_next    = right[Q_W-1];
            right_next = right;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[31:0] : rem_sh[31:0];
            quo_next = {quo_reg[46:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        mod_reg   <= mod_next;
        sl_reg    <= sl_next;
        sr_reg    <= sr_next;
        right_reg <= right_next;
    end

    // sign of quotient, then clamp to the q16.16 range
    always_comb
    begin
        if (sl_reg == sr_reg)
        begin
            q_val = (quo_reg > 48'h0000_7FFF_FFFF) ? Q_MAX : $signed(quo_reg[31:0]);
        end
        else
        begin
            q_val = (quo_reg > 48'h0000_8000_0000) ? Q_MIN : $signed(~quo_reg[31:0] + 32'd1);
        end
    end

    // truncated remainder takes the dividend sign, floor moves it to the divisor sign
    assign m_trunc = sl_reg ? -$signed({1'b0, rem_reg}) : $signed({1'b0, rem_reg});
    assign m_floor = ((rem_reg != 32'd0) && (sl_reg != sr_reg)) ? m_trunc + 33'(right_reg)
                                                                 : m_trunc;

    assign done   = done_reg;
    assign result = mod_reg ? m_floor[31:0] : q_val;

endmodule

[rtl/rpn_stack_calculator.sv]
// rpn stack calculator top level: sequencer, operand datapath and result register
// depends on rpn_pkg, rpn_token_if, rpn_result_if, rpn_mem and rpn_div
//
// token channel takes one kind and a q16.16 number per transfer; the result
// channel gives exactly one transfer per token, carrying the printed value
// and the overflow, underflow, zero divisor and unknown flags.
// tokens are handled one at a time, each pop going through the registered read
// port of the stack memory. push and unknown go straight to the result register;
// print, and divide or modulo by zero, stop after popping the right operand; add
// and subtract pop both operands, multiply adds a saturation step, and divide
// and modulo wait on the 48-step iterative divider. the next token is taken in
// the cycle after the result register is loaded.
// one result may wait while the next token is worked on; if the receiver keeps
// stalling, the block waits to hand over the next result and holds off tokens.
// reset empties the stack and drops any waiting result; stack contents
// themselves are not cleared, entries above the depth never reach an operand.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    rpn_token_if.sink     token,
    rpn_result_if.source  result
);
    import rpn_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    function automatic logic signed [Q_W-1:0] sat_sum(input logic signed [Q_W:0] v);
        if (v[Q_W] != v[Q_W-1])
        begin
            return v[Q_W] ? Q_MIN : Q_MAX;
        end
        return v[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] sat_prod(input logic signed [47:0] v);
        if ((&v[47:31]) || !(|v[47:31]))
        begin
            return v[Q_W-1:0];
        end
        return v[47] ? Q_MIN : Q_MAX;
    endfunction

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [DW-1:0]        depth_reg, depth_next;
    logic signed [Q_W-1:0] r_reg, r_next;
    logic signed [Q_W-1:0] l_reg, l_next;
    logic signed [63:0]   prod_reg, prod_next;
    logic signed [Q_W-1:0] val_reg, val_next;
    logic                 push_reg, push_next;
    logic                 show_reg, show_next;
    logic                 under_reg, under_next;
    logic                 zdiv_reg, zdiv_next;
    logic                 unk_reg, unk_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 o_shown_reg, o_shown_next;
    logic signed [Q_W-1:0] o_value_reg, o_value_next;
    logic                 o_over_reg, o_over_next;
    logic                 o_under_reg, o_under_next;
    logic                 o_zdiv_reg, o_zdiv_next;
    logic                 o_unk_reg, o_unk_next;

    logic                 accept;
    logic                 slot_free;
    logic                 full;
    logic                 empty;
    logic [DW-1:0]        depth_dec;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic signed [Q_W-1:0] rd_data;
    logic signed [Q_W-1:0] pop_val;
    logic                 is_divmod;
    div_ctrl_t            div_ctrl;
    logic                 div_done;
    logic signed [Q_W-1:0] div_result;

    assign accept    = token.valid && token.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign full      = (depth_reg == DW'(STACK_DEPTH));
    assign empty     = (depth_reg == '0);
    assign depth_dec = depth_reg - DW'(1);
    assign rd_addr   = depth_dec[AW-1:0];
    assign pop_val   = empty ? '0 : rd_data;
    assign is_divmod = (kind_reg == KIND_DIV) || (kind_reg == KIND_MOD);

    rpn_mem #(
        .DEPTH (STACK_DEPTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (depth_reg[AW-1:0]),
        .wr_data (val_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rpn_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (div_ctrl),
        .left   (l_reg),
        .right  (r_reg),
        .done   (div_done),
        .result (div_result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (token.valid)
                begin
                    if ((token.kind == KIND_PUSH) || (token.kind == KIND_UNKNOWN))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RD_R;
                    end
                end
            end
            ST_RD_R:
            begin
                state_next = ST_GET_R;
            end
            ST_GET_R:
            begin
                if ((kind_reg == KIND_SHOW) || (is_divmod && (pop_val == '0)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RD_L;
                end
            end
            ST_RD_L:
            begin
                state_next = ST_GET_L;
            end
            ST_GET_L:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (kind_reg == KIND_MUL)
                begin
                    state_next = ST_MUL_SAT;
                end
                else if (is_divmod)
                begin
                    state_next = ST_DIV_WAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL_SAT:
            begin
                state_next = ST_DONE;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next      = kind_reg;
        depth_next     = depth_reg;
        r_next         = r_reg;
        l_next         = l_reg;
        prod_next      = prod_reg;
        val_next       = val_reg;
        push_next      = push_reg;
        show_next      = show_reg;
        under_next     = under_reg;
        zdiv_next      = zdiv_reg;
        unk_next       = unk_reg;
        mem_we         = 1'b0;
        div_ctrl       = '0;
        out_valid_next = out_valid_reg && !result.ready;
        o_shown_next   = o_shown_reg;
        o_value_next   = o_value_reg;
        o_over_next    = o_over_reg;
        o_under_next   = o_under_reg;
        o_zdiv_next    = o_zdiv_reg;
        o_unk_next     = o_unk_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = token.kind;
                    val_next   = token.number;
                    push_next  = (token.kind == KIND_PUSH);
                    show_next  = 1'b0;
                    under_next = 1'b0;
                    zdiv_next  = 1'b0;
                    unk_next   = (token.kind == KIND_UNKNOWN);
                end
            end
            ST_GET_R:
            begin
                r_next = pop_val;
                if (empty)
                begin
                    under_next = 1'b1;
                end
                else
                begin
                    depth_next = depth_dec;
                end
                if (kind_reg == KIND_SHOW)
                begin
                    show_next = 1'b1;
                    val_next  = pop_val;
                end
                else if (is_divmod && (pop_val == '0))
                begin
                    zdiv_next = 1'b1;
                end
            end
            ST_GET_L:
            begin
                l_next = pop_val;
                if (empty)
                begin
                    under_next = 1'b1;
                end
                else
                begin
                    depth_next = depth_dec;
                end
            end
            ST_EXEC:
            begin
                case (kind_reg)
                    KIND_ADD:
                    begin
                        val_next  = sat_sum((Q_W+1)'(l_reg) + (Q_W+1)'(r_reg));
                        push_next = 1'b1;
                    end
                    KIND_SUB:
                    begin
                        val_next  = sat_sum((Q_W+1)'(l_reg) - (Q_W+1)'(r_reg));
                        push_next = 1'b1;
                    end
                    KIND_MUL:
                    begin
                        prod_next = l_reg * r_reg;
                    end
                    KIND_DIV, KIND_MOD:
                    begin
                        div_ctrl.start  = 1'b1;
                        div_ctrl.is_mod = (kind_reg == KIND_MOD);
                    end
                    default:
                    begin
                        push_next = 1'b0;
                    end
                endcase
            end
            ST_MUL_SAT:
            begin
                val_next  = sat_prod(prod_reg[63:16]);
                push_next = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    val_next  = div_result;
                    push_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    if (push_reg && !full)
                    begin
                        mem_we     = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                    out_valid_next = 1'b1;
                    o_shown_next   = show_reg;
                    o_value_next   = show_reg ? val_reg : '0;
                    o_over_next    = push_reg && full;
                    o_under_next   = under_reg;
                    o_zdiv_next    = zdiv_reg;
                    o_unk_next     = unk_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        r_reg       <= r_next;
        l_reg       <= l_next;
        prod_reg    <= prod_next;
        val_reg     <= val_next;
        push_reg    <= push_next;
        show_reg    <= show_next;
        under_reg   <= under_next;
        zdiv_reg    <= zdiv_next;
        unk_reg     <= unk_next;
        o_shown_reg <= o_shown_next;
        o_value_reg <= o_value_next;
        o_over_reg  <= o_over_next;
        o_under_reg <= o_under_next;
        o_zdiv_reg  <= o_zdiv_next;
        o_unk_reg   <= o_unk_next;
    end

    assign token.ready               = (state_reg == ST_IDLE);
    assign result.valid              = out_valid_reg;
    assign result.shown_valid        = o_shown_reg;
    assign result.shown_value        = o_value_reg;
    assign result.overflow_error     = o_over_reg;
    assign result.underflow_error    = o_under_reg;
    assign result.zero_divisor_error = o_zdiv_reg;
    assign result.unknown_error      = o_unk_reg;

endmodule

[rtl/rpn_checker.sv]
// port-level checks on the result channel of the rpn stack calculator
// depends on rpn_stack_calculator_assert.svh; bound to rpn_stack_calculator
`include "rpn_stack_calculator_assert.svh"

module rpn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic        shown_valid,
    input logic [31:0] shown_value,
    input logic        overflow_error,
    input logic        underflow_error,
    input logic        zero_divisor_error,
    input logic        unknown_error
);

    `RPN_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(shown_value) && $stable(shown_valid) && $stable(underflow_error) && $stable(zero_divisor_error), "result changed while stalled")

    `RPN_ASSERT_IMPLY(a_unknown_alone, result_valid && unknown_error, !overflow_error && !underflow_error && !zero_divisor_error && !shown_valid, "unknown token raised other flags")

    `RPN_ASSERT_IMPLY(a_quiet_value, result_valid && !shown_valid, shown_value == 32'd0, "value shown without a print")

    `RPN_ASSERT_IMPLY(a_overflow_push, result_valid && overflow_error, !underflow_error && !zero_divisor_error && !shown_valid, "overflow on a token that pops")

    `RPN_ASSERT_IMPLY(a_print_flags, result_valid && shown_valid, !zero_divisor_error && !overflow_error, "print transfer carries arithmetic flags")

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .shown_valid        (result.shown_valid),
    .shown_value        (result.shown_value),
    .overflow_error     (result.overflow_error),
    .underflow_error    (result.underflow_error),
    .zero_divisor_error (result.zero_divisor_error),
    .unknown_error      (result.unknown_error)
);

[tb/sv/tb_rpn_stack_calculator.sv]
// self-checking testbench for rpn_stack_calculator: directed corners, a full stack, receiver
// hold-off, random rpn expressions and noise, each result checked against a local predictor
// depends on rpn_pkg, rpn_token_if, rpn_result_if and the rpn_stack_calculator rtl
module tb_rpn_stack_calculator;
    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int DEPTH       = 128;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 50000;
    localparam int TAIL_CYCLES = 64;
    localparam longint TIMEOUT_NS = 64'd10_000_000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic               shown_valid;
        logic signed [31:0] shown_value;
        logic               overflow_error;
        logic               underflow_error;
        logic               zero_divisor_error;
        logic               unknown_error;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rpn_token_if  tok ();
    rpn_result_if res ();

    rpn_stack_calculator #(
        .STACK_DEPTH(DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .token (tok),
        .result(res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic signed [31:0] operand_model [DEPTH];
    int                 model_depth;
    outcome_t           pending_outcomes [$];

    int  burst_left;
    bit  long_hold_req;
    int  mismatches;
    int  results_checked;
    int  kind_count [8];
    int  overflow_seen;
    int  underflow_seen;
    int  zero_div_seen;

    function automatic logic signed [31:0] saturate_q(longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] pop_operand(inout logic under);
        if (model_depth > 0)
        begin
            model_depth--;
            return operand_model[model_depth];
        end
        under = 1'b1;
        return '0;
    endfunction

    function automatic void push_operand(logic signed [31:0] v, inout logic over);
        if (model_depth < DEPTH)
        begin
            operand_model[model_depth] = v;
            model_depth++;
        end
        else
            over = 1'b1;
    endfunction

    function automatic outcome_t predict_token(kind_t k, logic signed [31:0] num);
        outcome_t           o;
        logic               over;
        logic               under;
        logic signed [31:0] rv;
        logic signed [31:0] lv;
        longint             acc;
        o = '0;
        over = 1'b0;
        under = 1'b0;
        case (k)
            KIND_PUSH:
                push_operand(num, over);
            KIND_ADD, KIND_SUB, KIND_MUL:
            begin
                rv = pop_operand(under);
                lv = pop_operand(under);
                if (k == KIND_ADD)
                    acc = longint'(lv) + longint'(rv);
                else if (k == KIND_SUB)
                    acc = longint'(lv) - longint'(rv);
                else
                    acc = (longint'(lv) * longint'(rv)) >>> 16;
                push_operand(saturate_q(acc), over);
            end
            KIND_DIV, KIND_MOD:
            begin
                rv = pop_operand(under);
                if (rv == 0)
                    o.zero_divisor_error = 1'b1;
                else
                begin
                    lv = pop_operand(under);
                    if (k == KIND_DIV)
                        push_operand(saturate_q((longint'(lv) * 65536) / longint'(rv)), over);
                    else
                    begin
                        acc = longint'(lv) % longint'(rv);
                        if (acc != 0 && ((acc < 0) != (rv < 0)))
                            acc = acc + longint'(rv);
                        push_operand(acc[31:0], over);
                    end
                end
            end
            KIND_SHOW:
            begin
                o.shown_valid = 1'b1;
                o.shown_value = pop_operand(under);
            end
            default:
                o.unknown_error = 1'b1;
        endcase
        o.overflow_error = over;
        o.underflow_error = under;
        return o;
    endfunction

    function automatic logic signed [31:0] pick_number();
        case ($urandom_range(0, 11))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return 32'sh0000_0001;
            4:       return -32'sh0000_0001;
            5, 6:    return (int'($urandom_range(0, 200)) - 100) * 65536;
            7, 8:    return int'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_token(kind_t k, logic signed [31:0] num);
        int       gap;
        outcome_t o;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                tok.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        tok.valid  <= 1'b1;
        tok.kind   <= k;
        tok.number <= num;
        do
            @(posedge clk);
        while (!tok.ready);
        o = predict_token(k, num);
        pending_outcomes.push_back(o);
        kind_count[k]++;
        if (o.overflow_error)
            overflow_seen++;
        if (o.underflow_error)
            underflow_seen++;
        if (o.zero_divisor_error)
            zero_div_seen++;
    endtask

    task automatic drain_results();
        tok.valid <= 1'b0;
        burst_left = 0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_corners();
        send_token(KIND_SHOW, Q_MAX);
        send_token(KIND_ADD, '0);
        send_token(KIND_SHOW, '0);
        send_token(KIND_UNKNOWN, Q_MIN);
        send_token(KIND_DIV, '0);
        send_token(KIND_MOD, '0);
        send_token(KIND_PUSH, Q_MAX);
        send_token(KIND_PUSH, Q_MAX);
        send_token(KIND_ADD, '0);
        send_token(KIND_PUSH, Q_MIN);
        send_token(KIND_SUB, '0);
        send_token(KIND_PUSH, Q_MIN);
        send_token(KIND_MUL, '0);
        send_token(KIND_PUSH, -Q_ONE);
        send_token(KIND_DIV, '0);
        send_token(KIND_PUSH, '0);
        send_token(KIND_DIV, '0);
        send_token(KIND_PUSH, -3 * Q_ONE);
        send_token(KIND_MOD, '0);
        send_token(KIND_SHOW, '0);
        send_token(KIND_PUSH, 32'sh0000_0001);
        send_token(KIND_PUSH, -32'sh0000_0001);
        send_token(KIND_MUL, '0);
        send_token(KIND_MOD, '0);
        send_token(KIND_SHOW, '0);
    endtask

    task automatic test_stack_full();
        int i;
        drain_results();
        while (model_depth < DEPTH)
            send_token(KIND_PUSH, pick_number());
        for (i = 0; i < 3; i++)
            send_token(KIND_PUSH, pick_number());
        send_token(KIND_ADD, '0);
        send_token(KIND_PUSH, pick_number());
        send_token(KIND_PUSH, pick_number());
        while (model_depth > 0)
            send_token(kind_t'($urandom_range(KIND_ADD, KIND_SHOW)), pick_number());
    endtask

    task automatic test_backpressure();
        int i;
        long_hold_req = 1'b1;
        for (i = 0; i < 40; i++)
            send_token((i % 3 == 2) ? KIND_ADD : KIND_PUSH, pick_number());
        drain_results();
    endtask

    task automatic test_random_expressions(int count);
        int    i;
        int    r;
        kind_t k;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                k = kind_t'($urandom_range(0, 7));
            else if (model_depth < 2 || (model_depth < 10 && r < 50))
                k = KIND_PUSH;
            else if (r < 62)
                k = KIND_SHOW;
            else
                k = kind_t'($urandom_range(KIND_ADD, KIND_MOD));
            send_token(k, pick_number());
        end
    endtask

    task automatic test_random_noise(int count);
        int i;
        for (i = 0; i < count; i++)
            send_token(kind_t'($urandom_range(0, 7)), $urandom);
    endtask

    // receiver: long hold-off on request, otherwise a stall pattern that changes per segment
    initial
    begin : receiver
        int          seg;
        int          mode;
        int          hold;
        logic [31:0] mask;
        seg = 0;
        mode = 0;
        mask = '1;
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res.ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++)
                    @(posedge clk);
            end
            if (seg == 0)
            begin
                seg = $urandom_range(16, 96);
                mode = $urandom_range(0, 3);
                mask = $urandom;
            end
            seg--;
            case (mode)
                0:       res.ready <= 1'b1;
                1:       res.ready <= $urandom_range(0, 1);
                2:       res.ready <= (seg % 4 == 0);
                default: res.ready <= mask[seg % 32];
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t seen;
        outcome_t want;
        if (rst_n && res.valid && res.ready)
        begin
            seen.shown_valid        = res.shown_valid;
            seen.shown_value        = res.shown_value;
            seen.overflow_error     = res.overflow_error;
            seen.underflow_error    = res.underflow_error;
            seen.zero_divisor_error = res.zero_divisor_error;
            seen.unknown_error      = res.unknown_error;
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transfer at %0t: shown %0b value %0d",
                             $realtime, seen.shown_valid, seen.shown_value);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (seen.shown_valid !== want.shown_valid
                    || seen.shown_value !== want.shown_value
                    || seen.overflow_error !== want.overflow_error
                    || seen.underflow_error !== want.underflow_error
                    || seen.zero_divisor_error !== want.zero_divisor_error
                    || seen.unknown_error !== want.unknown_error)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result %0d mismatch: expected shown %0b value %0d ovf %0b ",
                                  "unf %0b zdiv %0b unk %0b, got shown %0b value %0d ovf %0b ",
                                  "unf %0b zdiv %0b unk %0b"},
                                 results_checked, want.shown_valid, want.shown_value,
                                 want.overflow_error, want.underflow_error,
                                 want.zero_divisor_error, want.unknown_error,
                                 seen.shown_valid, seen.shown_value, seen.overflow_error,
                                 seen.underflow_error, seen.zero_divisor_error,
                                 seen.unknown_error);
                end
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int waited;
        tok.valid = 1'b0;
        tok.kind = KIND_PUSH;
        tok.number = '0;
        model_depth = 0;
        burst_left = 0;
        long_hold_req = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_stack_full();
        test_backpressure();
        test_random_expressions(1250);
        test_random_noise(150);

        tok.valid <= 1'b0;
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", pending_outcomes.size());
        end

        $display({"covered %0d pushes, %0d arithmetic tokens, %0d prints, %0d unknown; ",
                  "%0d results checked"},
                 kind_count[KIND_PUSH],
                 kind_count[KIND_ADD] + kind_count[KIND_SUB] + kind_count[KIND_MUL]
                     + kind_count[KIND_DIV] + kind_count[KIND_MOD],
                 kind_count[KIND_SHOW], kind_count[KIND_UNKNOWN], results_checked);
        $display("stack overflow %0d, underflow %0d, zero divisor %0d; %0d mismatches",
                 overflow_seen, underflow_seen, zero_div_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rpn_pkg.sv
rtl/rpn_token_if.sv
rtl/rpn_result_if.sv
rtl/rpn_mem.sv
rtl/rpn_div.sv
rtl/rpn_stack_calculator.sv
rtl/rpn_checker.sv
tb/sv/tb_rpn_stack_calculator.sv
